// ===== design/lsps_pkg.sv =====
// ----------------------------------------------------------------------------
// lsps_pkg: shared types and constants for the lidar sector proximity select
// Register codes, reset values, sector codes and the structs passed between
// the stages of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package lsps_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam int RANGE_W     = 16;
  localparam int THRESHOLD_W = 16;
  localparam int START_W     = 17;
  localparam int STEP_W      = 12;
  localparam int MIN_HITS_W  = 13;

  localparam logic [THRESHOLD_W-1:0]    THRESHOLD_RST = 16'd600;
  localparam logic signed [START_W-1:0] START_RST     = -17'sd46080;
  localparam logic [STEP_W-1:0]         STEP_RST      = 12'd22;

  localparam int DEG45  = 45 * 256;
  localparam int DEG135 = 135 * 256;

  typedef enum logic [1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_START_ANGLE = 2'd1,
    REG_ANGLE_STEP  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEC_BACK  = 2'd0,
    SEC_RIGHT = 2'd1,
    SEC_FRONT = 2'd2,
    SEC_LEFT  = 2'd3
  } sector_t;

  typedef struct packed {
    logic [THRESHOLD_W-1:0]    threshold_mm;
    logic signed [START_W-1:0] start_angle;
    logic [STEP_W-1:0]         angle_step;
  } cfg_t;

  typedef struct packed {
    logic    close;
    logic    hit;
    sector_t sector;
    logic    last;
  } class_t;

  typedef struct packed {
    logic                  any_close;
    sector_t               direction;
    logic                  direction_changed;
    logic [MIN_HITS_W-1:0] min_hits;
  } result_t;

endpackage

`default_nettype wire

// ===== design/lsps_if.sv =====
// ----------------------------------------------------------------------------
// lsps_if: streaming channels of the lidar sector proximity select
// Sample channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsps_in_if;
  logic                           valid;
  logic                           ready;
  logic [lsps_pkg::RANGE_W-1:0]   range_mm;
  logic                           last_of_scan;

  modport source (output valid, output range_mm, output last_of_scan, input ready);
  modport sink   (input valid, input range_mm, input last_of_scan, output ready);
endinterface

interface lsps_out_if;
  logic                              valid;
  logic                              ready;
  logic                              any_close;
  logic [1:0]                        direction;
  logic                              direction_changed;
  logic [lsps_pkg::MIN_HITS_W-1:0]   min_hits;

  modport source (output valid, output any_close, output direction,
                  output direction_changed, output min_hits, input ready);
  modport sink   (input valid, input any_close, input direction,
                  input direction_changed, input min_hits, output ready);
endinterface

`default_nettype wire

// ===== design/lsps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lsps_cfg_regs: APB-style configuration registers
// Holds threshold, start angle and angle step; write on the access phase,
// read back the selected register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsps_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lsps_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [lsps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [lsps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output lsps_pkg::cfg_t                       cfg
);

  lsps_pkg::cfg_t cfg_r;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_mm <= lsps_pkg::THRESHOLD_RST;
      cfg_r.start_angle  <= lsps_pkg::START_RST;
      cfg_r.angle_step   <= lsps_pkg::STEP_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        lsps_pkg::REG_THRESHOLD:   cfg_r.threshold_mm <= pwdata[lsps_pkg::THRESHOLD_W-1:0];
        lsps_pkg::REG_START_ANGLE: cfg_r.start_angle  <= $signed(pwdata[lsps_pkg::START_W-1:0]);
        lsps_pkg::REG_ANGLE_STEP:  cfg_r.angle_step   <= pwdata[lsps_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lsps_pkg::REG_THRESHOLD:   prdata = lsps_pkg::CFG_DATA_W'(cfg_r.threshold_mm);
      lsps_pkg::REG_START_ANGLE: prdata = lsps_pkg::CFG_DATA_W'(cfg_r.start_angle);
      lsps_pkg::REG_ANGLE_STEP:  prdata = lsps_pkg::CFG_DATA_W'(cfg_r.angle_step);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/lsps_angle_stage.sv =====
// ----------------------------------------------------------------------------
// lsps_angle_stage: sample index, angle and sector classification
// Stage one registers the threshold compare and step times index; stage two
// adds the start angle and registers the sector of the sample.
// ----------------------------------------------------------------------------
`default_nettype none

module lsps_angle_stage #(
  parameter int MAX_SAMPLES = lsps_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [lsps_pkg::RANGE_W-1:0] in_range_mm,
  input  wire logic                         in_last_of_scan,
  input  wire lsps_pkg::cfg_t               cfg,
  output logic                              cls_valid,
  output lsps_pkg::class_t                  cls,
  input  wire logic                         cls_ready
);

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int PW = lsps_pkg::STEP_W + IW;
  localparam int AW = PW + 2;
  localparam logic [IW-1:0]        IDX_MAX  = IW'(MAX_SAMPLES - 1);
  localparam logic signed [AW-1:0] POS_D45  = AW'(lsps_pkg::DEG45);
  localparam logic signed [AW-1:0] NEG_D45  = AW'(-lsps_pkg::DEG45);
  localparam logic signed [AW-1:0] POS_D135 = AW'(lsps_pkg::DEG135);
  localparam logic signed [AW-1:0] NEG_D135 = AW'(-lsps_pkg::DEG135);

  logic [IW-1:0]     idx_r, idx_nxt;
  logic              s1_valid_r;
  logic              s1_close_r;
  logic              s1_last_r;
  logic [PW-1:0]     s1_prod_r;
  logic              s2_valid_r;
  lsps_pkg::class_t  s2_cls_r, cls_nxt;
  logic              s2_free;
  logic              accept;
  logic signed [AW-1:0] angle;

  assign s2_free   = !s2_valid_r || cls_ready;
  assign in_ready  = !s1_valid_r || s2_free;
  assign accept    = in_valid && in_ready;
  assign cls_valid = s2_valid_r;
  assign cls       = s2_cls_r;

  always_comb begin
    if (in_last_of_scan) begin
      idx_nxt = '0;
    end else if (idx_r != IDX_MAX) begin
      idx_nxt = idx_r + IW'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_comb begin
    angle          = AW'(cfg.start_angle) + $signed({2'b00, s1_prod_r});
    cls_nxt.close  = s1_close_r;
    cls_nxt.last   = s1_last_r;
    cls_nxt.hit    = s1_close_r;
    cls_nxt.sector = lsps_pkg::SEC_BACK;
    if (angle > NEG_D45 && angle < POS_D45) begin
      cls_nxt.sector = lsps_pkg::SEC_BACK;
    end else if (angle > POS_D45 && angle < POS_D135) begin
      cls_nxt.sector = lsps_pkg::SEC_RIGHT;
    end else if (angle > POS_D135 || angle < NEG_D135) begin
      cls_nxt.sector = lsps_pkg::SEC_FRONT;
    end else if (angle < NEG_D45 && angle > NEG_D135) begin
      cls_nxt.sector = lsps_pkg::SEC_LEFT;
    end else begin
      cls_nxt.hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        idx_r <= idx_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_close_r <= in_range_mm < cfg.threshold_mm;
      s1_last_r  <= in_last_of_scan;
      s1_prod_r  <= PW'(cfg.angle_step) * PW'(idx_r);
    end
    if (s2_free && s1_valid_r) begin
      s2_cls_r <= cls_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/lsps_sector_accum.sv =====
// ----------------------------------------------------------------------------
// lsps_sector_accum: per-sector hit counters and scan result register
// Count hits per sector, pick the least occupied sector at scan end, track
// the last reported sector and hold the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lsps_sector_accum #(
  parameter int MAX_SAMPLES = lsps_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cls_valid,
  input  wire lsps_pkg::class_t cls,
  output logic                  cls_ready,
  output logic                  out_valid,
  output lsps_pkg::result_t     out_res,
  input  wire logic             out_ready
);

  localparam int HW = $clog2(MAX_SAMPLES + 1);
  localparam logic [HW-1:0] HITS_MAX = HW'(MAX_SAMPLES);

  logic [HW-1:0]     hits_r [4];
  logic [HW-1:0]     hits_upd [4];
  logic              close_seen_r;
  logic              rep_valid_r;
  lsps_pkg::sector_t rep_sector_r;
  logic              out_valid_r;
  lsps_pkg::result_t out_res_r, res_nxt;
  logic              slot_free;
  logic              take;
  logic              close_nxt;
  logic              lt01, lt3, lt2;
  lsps_pkg::sector_t sec_a, sec_b, dir;
  logic [HW-1:0]     h_a, h_b, h_min;

  assign slot_free = !out_valid_r || out_ready;
  assign cls_ready = !cls.last || slot_free;
  assign take      = cls_valid && cls_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign close_nxt = close_seen_r || cls.close;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hits_upd[i] = hits_r[i] + HW'(cls.hit && (cls.sector == 2'(i)) && (hits_r[i] != HITS_MAX));
    end
  end

  always_comb begin
    lt01  = hits_upd[0] < hits_upd[1];
    sec_a = lt01 ? lsps_pkg::SEC_BACK : lsps_pkg::SEC_RIGHT;
    h_a   = lt01 ? hits_upd[0] : hits_upd[1];
    lt3   = h_a < hits_upd[3];
    sec_b = lt3 ? sec_a : lsps_pkg::SEC_LEFT;
    h_b   = lt3 ? h_a : hits_upd[3];
    lt2   = h_b < hits_upd[2];
    dir   = lt2 ? sec_b : lsps_pkg::SEC_FRONT;
    h_min = lt2 ? h_b : hits_upd[2];

    res_nxt.any_close         = close_nxt;
    res_nxt.direction         = dir;
    res_nxt.direction_changed = close_nxt && (!rep_valid_r || dir != rep_sector_r);
    res_nxt.min_hits          = lsps_pkg::MIN_HITS_W'(h_min);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        hits_r[i] <= '0;
      end
      close_seen_r <= 1'b0;
      rep_valid_r  <= 1'b0;
      rep_sector_r <= lsps_pkg::SEC_BACK;
      out_valid_r  <= 1'b0;
    end else begin
      if (take && cls.last) begin
        for (int i = 0; i < 4; i++) begin
          hits_r[i] <= '0;
        end
        close_seen_r <= 1'b0;
        if (close_nxt) begin
          rep_valid_r  <= 1'b1;
          rep_sector_r <= dir;
        end
        out_valid_r <= 1'b1;
      end else begin
        if (take) begin
          hits_r       <= hits_upd;
          close_seen_r <= close_nxt;
        end
        if (out_ready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && cls.last) begin
      out_res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/lidar_sector_proximity_select_top.sv =====
// ----------------------------------------------------------------------------
// lidar_sector_proximity_select_top: close obstacle sector selection
// Counts close lidar samples per angular sector and reports the least
// occupied sector at the end of each scan.
//
//   channel   | direction | transaction
//   ----------+-----------+---------------------------------------------------
//   in_if     | sink      | one range sample, last_of_scan closes the scan
//   out_if    | source    | one scan result, only for a sample with last flag
//   psel/...  | APB slave | register write/read, pready always high
//
// One sample per cycle sustained; after its last sample is accepted, a result
// passes the multiply stage, the sector stage and the result register.
// Synchronous active-low reset clears valids and counters, presets registers.
// Input stalls only while a scan-end sample waits behind an untaken result.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_sector_proximity_select_top #(
  parameter int MAX_SAMPLES = lsps_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  lsps_in_if.sink                              in_if,
  lsps_out_if.source                           out_if,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lsps_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [lsps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [lsps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);

  lsps_pkg::cfg_t    cfg;
  logic              cls_valid;
  logic              cls_ready;
  lsps_pkg::class_t  cls;
  lsps_pkg::result_t res;

  lsps_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsps_angle_stage #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_angle (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_if.valid),
    .in_ready        (in_if.ready),
    .in_range_mm     (in_if.range_mm),
    .in_last_of_scan (in_if.last_of_scan),
    .cfg             (cfg),
    .cls_valid       (cls_valid),
    .cls             (cls),
    .cls_ready       (cls_ready)
  );

  lsps_sector_accum #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (cls_valid),
    .cls       (cls),
    .cls_ready (cls_ready),
    .out_valid (out_if.valid),
    .out_res   (res),
    .out_ready (out_if.ready)
  );

  assign out_if.any_close         = res.any_close;
  assign out_if.direction         = res.direction;
  assign out_if.direction_changed = res.direction_changed;
  assign out_if.min_hits          = res.min_hits;

`ifndef ASSERT_OFF
  a_changed_needs_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (!out_if.direction_changed || out_if.any_close))
    else $error("direction_changed without any_close");

  a_quiet_scan_front: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.any_close) |->
      (out_if.min_hits == '0 && out_if.direction == lsps_pkg::SEC_FRONT))
    else $error("scan without close samples must report front with zero hits");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (out_if.valid && !out_if.ready))
    else $error("input stalled while result path is free");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for lidar_sector_proximity_select_top
// Sends range samples in scans; between scans, drives the register port with
// several threshold, start angle and step settings. A local sector-count model
// predicts each scan result, and each result is checked field by field.
// Both channel sides idle at random.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [2:0] NO_SECTOR = 3'd4;
  localparam int QUIET_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [lsps_pkg::CFG_ADDR_W-1:0] paddr;
  logic [lsps_pkg::CFG_DATA_W-1:0] pwdata;
  logic [lsps_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  lsps_in_if  sample_ch ();
  lsps_out_if result_ch ();

  lidar_sector_proximity_select_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (sample_ch),
    .out_if  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  logic [lsps_pkg::THRESHOLD_W-1:0]    thr_q   = lsps_pkg::THRESHOLD_RST;
  logic signed [lsps_pkg::START_W-1:0] start_q = lsps_pkg::START_RST;
  logic [lsps_pkg::STEP_W-1:0]         step_q  = lsps_pkg::STEP_RST;

  int unsigned scan_idx = 0;
  int unsigned sector_hits_q [4] = '{0, 0, 0, 0};
  bit          scan_close = 1'b0;
  logic [2:0]  last_dir = NO_SECTOR;

  lsps_pkg::result_t pending_results [$];
  lsps_pkg::result_t exp_r;

  int errors = 0;
  int samples_sent = 0;
  int scans_checked = 0;
  int close_scans = 0;
  int sector_changes = 0;
  int reg_writes = 0;
  int in_max_gap = 16;
  int out_max_gap = 16;
  int hold_left = 0;
  int quiet = 0;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic bit sector_of_angle(longint a, output lsps_pkg::sector_t s);
    s = lsps_pkg::SEC_BACK;
    if (a > -lsps_pkg::DEG45 && a < lsps_pkg::DEG45) begin
      s = lsps_pkg::SEC_BACK;
      return 1'b1;
    end
    if (a > lsps_pkg::DEG45 && a < lsps_pkg::DEG135) begin
      s = lsps_pkg::SEC_RIGHT;
      return 1'b1;
    end
    if (a > lsps_pkg::DEG135 || a < -lsps_pkg::DEG135) begin
      s = lsps_pkg::SEC_FRONT;
      return 1'b1;
    end
    if (a < -lsps_pkg::DEG45 && a > -lsps_pkg::DEG135) begin
      s = lsps_pkg::SEC_LEFT;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic lsps_pkg::sector_t least_sector();
    lsps_pkg::sector_t s;
    s = (sector_hits_q[lsps_pkg::SEC_BACK] < sector_hits_q[lsps_pkg::SEC_RIGHT]) ?
        lsps_pkg::SEC_BACK : lsps_pkg::SEC_RIGHT;
    if (!(sector_hits_q[s] < sector_hits_q[lsps_pkg::SEC_LEFT])) s = lsps_pkg::SEC_LEFT;
    if (!(sector_hits_q[s] < sector_hits_q[lsps_pkg::SEC_FRONT])) s = lsps_pkg::SEC_FRONT;
    return s;
  endfunction

  function automatic void tally_sample(logic [lsps_pkg::RANGE_W-1:0] rng, bit last);
    lsps_pkg::sector_t s;
    longint a;
    lsps_pkg::result_t r;
    if (rng < thr_q) begin
      a = longint'(start_q) + longint'(step_q) * longint'(scan_idx);
      scan_close = 1'b1;
      if (sector_of_angle(a, s) && sector_hits_q[s] < lsps_pkg::MAX_SAMPLES_DEF)
        sector_hits_q[s]++;
    end
    if (scan_idx < lsps_pkg::MAX_SAMPLES_DEF - 1) scan_idx++;
    if (last) begin
      r.direction = least_sector();
      r.any_close = scan_close;
      r.direction_changed = scan_close && ({1'b0, r.direction} != last_dir);
      r.min_hits = lsps_pkg::MIN_HITS_W'(sector_hits_q[r.direction]);
      if (scan_close) last_dir = {1'b0, r.direction};
      pending_results.push_back(r);
      scan_idx = 0;
      sector_hits_q = '{0, 0, 0, 0};
      scan_close = 1'b0;
    end
  endfunction

  function automatic logic [lsps_pkg::RANGE_W-1:0] draw_range();
    case ($urandom_range(7))
      0, 1, 2: return (thr_q == 0) ? 16'd0 : 16'($urandom_range(thr_q - 1, 0));
      3:       return 16'hFFFF;
      4:       return thr_q;
      5:       return thr_q - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // predict on every accepted sample
  always @(posedge clk) begin
    if (rst_n && sample_ch.valid && sample_ch.ready) begin
      samples_sent++;
      tally_sample(sample_ch.range_mm, sample_ch.last_of_scan);
    end
  end

  // check every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && result_ch.valid && result_ch.ready) begin
      hold_left <= $urandom_range(out_max_gap, 0);
      scans_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with no scan pending");
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.any_close) close_scans++;
        if (exp_r.direction_changed) sector_changes++;
        if (result_ch.any_close !== exp_r.any_close)
          report_mismatch($sformatf("any_close exp %0d got %0d",
                                    exp_r.any_close, result_ch.any_close));
        if (result_ch.direction !== exp_r.direction)
          report_mismatch($sformatf("direction exp %0d got %0d",
                                    exp_r.direction, result_ch.direction));
        if (result_ch.direction_changed !== exp_r.direction_changed)
          report_mismatch($sformatf("direction_changed exp %0d got %0d",
                                    exp_r.direction_changed, result_ch.direction_changed));
        if (result_ch.min_hits !== exp_r.min_hits)
          report_mismatch($sformatf("min_hits exp %0d got %0d",
                                    exp_r.min_hits, result_ch.min_hits));
      end
    end
  end

  // stall the result side
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (psel && penable)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(lsps_pkg::reg_idx_t r, logic [lsps_pkg::CFG_DATA_W-1:0] v);
    logic [lsps_pkg::CFG_DATA_W-1:0] mask;
    case (r)
      lsps_pkg::REG_THRESHOLD:   mask = (32'd1 << lsps_pkg::THRESHOLD_W) - 1;
      lsps_pkg::REG_START_ANGLE: mask = (32'd1 << lsps_pkg::START_W) - 1;
      default:                   mask = (32'd1 << lsps_pkg::STEP_W) - 1;
    endcase
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (r)
      lsps_pkg::REG_THRESHOLD:   thr_q = v[lsps_pkg::THRESHOLD_W-1:0];
      lsps_pkg::REG_START_ANGLE: start_q = signed'(v[lsps_pkg::START_W-1:0]);
      default:                   step_q = v[lsps_pkg::STEP_W-1:0];
    endcase
    reg_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata & mask) !== (v & mask))
      report_mismatch($sformatf("register %s read exp %0h got %0h",
                                r.name(), v & mask, prdata & mask));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_sample(logic [lsps_pkg::RANGE_W-1:0] rng, bit last);
    int gap;
    gap = $urandom_range(in_max_gap, 0);
    if (gap > 0) begin
      @(negedge clk);
      sample_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sample_ch.valid <= 1'b1;
    sample_ch.range_mm <= rng;
    sample_ch.last_of_scan <= last;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_range_extremes();
    send_sample(16'd0, 1'b0);
    send_sample(16'd599, 1'b0);
    send_sample(16'd600, 1'b0);
    send_sample(16'd601, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'd0, 1'b1);
  endtask

  task automatic test_empty_scan();
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd600, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
  endtask

  task automatic test_threshold_extremes();
    wait_idle();
    write_reg(lsps_pkg::REG_THRESHOLD, 32'd0);
    send_sample(16'd0, 1'b1);
    wait_idle();
    write_reg(lsps_pkg::REG_THRESHOLD, 32'hFFFF);
    send_sample(16'hFFFE, 1'b0);
    send_sample(16'hFFFF, 1'b1);
  endtask

  task automatic test_boundary_angles();
    int b [4];
    b = '{lsps_pkg::DEG45, -lsps_pkg::DEG45, lsps_pkg::DEG135, -lsps_pkg::DEG135};
    wait_idle();
    write_reg(lsps_pkg::REG_THRESHOLD, 32'd600);
    write_reg(lsps_pkg::REG_ANGLE_STEP, 32'd0);
    foreach (b[k]) begin
      wait_idle();
      write_reg(lsps_pkg::REG_START_ANGLE, 32'(b[k]));
      send_sample(16'd10, 1'b1);
    end
  endtask

  task automatic test_random_scans();
    int n;
    int sent;
    logic [lsps_pkg::CFG_DATA_W-1:0] v;
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      in_max_gap = (phase % 3 == 0) ? 0 : 16;
      out_max_gap = (phase % 4 == 1) ? 0 : 16;
      v = $urandom;
      case (phase)
        1:       v[15:0] = 16'd0;
        2:       v[15:0] = 16'hFFFF;
        default: v[15:0] = ($urandom_range(2) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(3000, 1));
      endcase
      write_reg(lsps_pkg::REG_THRESHOLD, v);
      v = $urandom;
      case (phase)
        3:       v[16:0] = 17'h10000;
        4:       v[16:0] = 17'h0FFFF;
        5:       v[16:0] = 17'(-46080);
        6:       v[16:0] = 17'(46080);
        default: v[16:0] = 17'(int'($urandom_range(92160)) - 46080);
      endcase
      write_reg(lsps_pkg::REG_START_ANGLE, v);
      v = $urandom;
      case (phase)
        0:       v[11:0] = 12'd22;
        3:       v[11:0] = 12'hFFF;
        4:       v[11:0] = 12'd0;
        5:       v[11:0] = 12'd2560;
        default: v[11:0] = 12'($urandom);
      endcase
      write_reg(lsps_pkg::REG_ANGLE_STEP, v);
      sent = 0;
      while (sent < 50) begin
        n = ($urandom_range(11) == 0) ? $urandom_range(200, 49) : $urandom_range(48, 1);
        for (int i = 0; i < n; i++) send_sample(draw_range(), i == n - 1);
        sent += n;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.range_mm = '0;
    sample_ch.last_of_scan = 1'b0;
    result_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_range_extremes();
    test_empty_scan();
    test_threshold_extremes();
    test_boundary_angles();
    test_random_scans();
    wait_idle();

    $display("covered %0d samples, %0d scan results (%0d with close samples, %0d sector changes)",
             samples_sent, scans_checked, close_scans, sector_changes);
    $display("register writes: %0d, mismatches: %0d", reg_writes, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
